>>> hw/rtl/dec_hex_unsigned_parser_defines.svh
// ----------------------------------------------------------------------------
// dec_hex_unsigned_parser assertion macros
// Clocked assertion helpers shared by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef DEC_HEX_UNSIGNED_PARSER_DEFINES_SVH
`define DEC_HEX_UNSIGNED_PARSER_DEFINES_SVH

// check a property on every clock edge outside reset
`define DHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check a property on every clock edge, reset included
`define DHP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/dhp_pkg.sv
// ----------------------------------------------------------------------------
// dhp_pkg
// Shared types and constants of the decimal/hex unsigned parser.
// ----------------------------------------------------------------------------
package dhp_pkg;

  localparam int CHAR_BITS   = 8;
  localparam int RESULT_BITS = 32;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 16;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic [STATUS_BITS-1:0] ST_OK             = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EXPECTED_DIGIT = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_TOO_LARGE      = 2'd2;

  localparam logic [CHAR_BITS-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LOWER_F = 8'h66;
  localparam logic [CHAR_BITS-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UPPER_F = 8'h46;
  localparam logic [CHAR_BITS-1:0] CH_LOWER_X = 8'h78;
  localparam logic [CHAR_BITS-1:0] CH_UPPER_X = 8'h58;

  typedef struct packed {
    logic [RESULT_BITS-1:0] value;
    logic [STATUS_BITS-1:0] status;
    logic [COUNT_BITS-1:0]  consumed;
    logic                   was_hex;
  } result_t;

endpackage

>>> hw/rtl/dhp_text_if.sv
// ----------------------------------------------------------------------------
// dhp_text_if
// Character channel: one ASCII byte or end marker per beat.
// ----------------------------------------------------------------------------
interface dhp_text_if;

  logic                          valid;
  logic                          ready;
  logic [dhp_pkg::CHAR_BITS-1:0] ch;
  logic                          at_end;

  modport source (output valid, ch, at_end, input ready);
  modport sink   (input valid, ch, at_end, output ready);

endinterface

>>> hw/rtl/dhp_result_if.sv
// ----------------------------------------------------------------------------
// dhp_result_if
// Result channel: one parsed number per beat.
// ----------------------------------------------------------------------------
interface dhp_result_if;

  logic                            valid;
  logic                            ready;
  logic [dhp_pkg::RESULT_BITS-1:0] value;
  logic [dhp_pkg::STATUS_BITS-1:0] status;
  logic [dhp_pkg::COUNT_BITS-1:0]  consumed;
  logic                            was_hex;

  modport source (output valid, value, status, consumed, was_hex, input ready);
  modport sink   (input valid, value, status, consumed, was_hex, output ready);

endinterface

>>> hw/rtl/dhp_core.sv
// ----------------------------------------------------------------------------
// dhp_core
// Input register, parse state and combinational digit accumulation.
// ----------------------------------------------------------------------------
`include "dec_hex_unsigned_parser_defines.svh"

module dhp_core #(
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dhp_pkg::CHAR_BITS-1:0] in_ch,
  input  logic                          in_at_end,
  output logic                          res_valid,
  input  logic                          res_ready,
  output dhp_pkg::result_t              res
);
  import dhp_pkg::*;

  localparam int PROD_BITS = VALUE_BITS + 4;
  localparam int SUM_BITS  = VALUE_BITS + 5;

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_ZEROS  = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;

  logic                  in_valid_q;
  logic [CHAR_BITS-1:0]  ch_q;
  logic                  at_end_q;

  logic [1:0]            phase, phase_next;
  logic [VALUE_BITS-1:0] acc, acc_next;
  logic [COUNT_BITS-1:0] char_count, char_count_next;
  logic                  hex_mode, hex_mode_next;

  logic                  is_dec, is_lower, is_upper, is_x, dig_ok;
  logic [3:0]            dig;
  logic [COUNT_BITS-1:0] count_inc;
  logic [PROD_BITS-1:0]  prod;
  logic [SUM_BITS-1:0]   total;
  logic                  overflow;
  logic                  emit, advance;
  logic [VALUE_BITS-1:0] emit_val;
  logic [STATUS_BITS-1:0] emit_status;
  logic [VALUE_BITS+RESULT_BITS-1:0] value_wide;

  always_comb begin
    is_dec   = (ch_q >= CH_ZERO) && (ch_q <= CH_NINE);
    is_lower = (ch_q >= CH_LOWER_A) && (ch_q <= CH_LOWER_F);
    is_upper = (ch_q >= CH_UPPER_A) && (ch_q <= CH_UPPER_F);
    is_x     = (ch_q == CH_LOWER_X) || (ch_q == CH_UPPER_X);
    dig_ok   = is_dec || (hex_mode && (is_lower || is_upper));
    if (is_lower) begin
      dig = 4'(ch_q - CH_LOWER_A + 8'd10);
    end else if (is_upper) begin
      dig = 4'(ch_q - CH_UPPER_A + 8'd10);
    end else begin
      dig = 4'(ch_q - CH_ZERO);
    end
    count_inc = (char_count == COUNT_MAX) ? char_count : char_count + 1'b1;
    if (hex_mode) begin
      prod = {acc, 4'b0000};
    end else begin
      prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
    end
    total    = {1'b0, prod} + {{(SUM_BITS-4){1'b0}}, dig};
    overflow = |total[SUM_BITS-1:VALUE_BITS];
  end

  always_comb begin
    emit            = 1'b0;
    emit_val        = '0;
    emit_status     = ST_OK;
    phase_next      = phase;
    acc_next        = acc;
    char_count_next = char_count;
    hex_mode_next   = hex_mode;
    case (phase)
      PH_START: begin
        if (at_end_q || !is_dec) begin
          emit        = 1'b1;
          emit_status = ST_EXPECTED_DIGIT;
        end else begin
          acc_next        = {{(VALUE_BITS-4){1'b0}}, dig};
          char_count_next = {{(COUNT_BITS-1){1'b0}}, 1'b1};
          hex_mode_next   = 1'b0;
          phase_next      = (ch_q == CH_ZERO) ? PH_ZEROS : PH_DIGITS;
        end
      end
      PH_ZEROS, PH_DIGITS: begin
        if (at_end_q) begin
          emit     = 1'b1;
          emit_val = acc;
        end else if ((phase == PH_ZEROS) && (ch_q == CH_ZERO)) begin
          char_count_next = count_inc;
        end else if ((phase == PH_ZEROS) && is_x) begin
          char_count_next = count_inc;
          hex_mode_next   = 1'b1;
          acc_next        = '0;
          phase_next      = PH_DIGITS;
        end else if (!dig_ok) begin
          emit     = 1'b1;
          emit_val = acc;
        end else if (overflow) begin
          emit        = 1'b1;
          emit_status = ST_TOO_LARGE;
        end else begin
          acc_next        = total[VALUE_BITS-1:0];
          char_count_next = count_inc;
          phase_next      = PH_DIGITS;
        end
      end
      default: begin
        phase_next = PH_START;
      end
    endcase
    if (emit) begin
      phase_next      = PH_START;
      acc_next        = '0;
      char_count_next = '0;
      hex_mode_next   = 1'b0;
    end
  end

  assign advance   = in_valid_q && (!emit || res_ready);
  assign in_ready  = !in_valid_q || advance;
  assign res_valid = in_valid_q && emit;

  assign value_wide   = {{RESULT_BITS{1'b0}}, emit_val};
  assign res.value    = value_wide[RESULT_BITS-1:0];
  assign res.status   = emit_status;
  assign res.consumed = char_count;
  assign res.was_hex  = hex_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
    if (in_valid && in_ready) begin
      ch_q     <= in_ch;
      at_end_q <= in_at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      acc        <= '0;
      char_count <= '0;
      hex_mode   <= 1'b0;
    end else if (advance) begin
      phase      <= phase_next;
      acc        <= acc_next;
      char_count <= char_count_next;
      hex_mode   <= hex_mode_next;
    end
  end

  `DHP_ASSERT(a_restart_after_emit, (advance && emit) |=> (phase == PH_START && char_count == '0), "parse state not cleared after result")
  `DHP_ASSERT(a_hex_only_in_digits, !hex_mode || (phase == PH_DIGITS), "hex mode outside digit phase")
  `DHP_ASSERT(a_too_large_zero, (res_valid && res.status == ST_TOO_LARGE) |-> (res.value == '0), "too large result carries a value")
  `DHP_ASSERT(a_bad_start_empty, (res_valid && res.status == ST_EXPECTED_DIGIT) |-> (res.consumed == '0 && !res.was_hex), "bad first item with consumed characters")

endmodule

>>> hw/rtl/dhp_skid.sv
// ----------------------------------------------------------------------------
// dhp_skid
// Two-entry result buffer with registered ready towards the core.
// ----------------------------------------------------------------------------
`include "dec_hex_unsigned_parser_defines.svh"

module dhp_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  dhp_pkg::result_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output dhp_pkg::result_t pop_data
);
  import dhp_pkg::*;

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;
  logic    push, pop;

  assign push_ready = !skid_valid;
  assign pop_valid  = main_valid;
  assign pop_data   = main_data;
  assign push       = push_valid && push_ready;
  assign pop        = main_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (push) begin
        main_data <= push_data;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

  `DHP_ASSERT_ALWAYS(a_skid_behind_main, rst || !skid_valid || main_valid, "skid entry without main entry")
  `DHP_ASSERT(a_skid_drains, (pop && skid_valid) |=> !skid_valid, "skid entry not moved on pop")
  `DHP_ASSERT(a_skid_fills, (push && main_valid && !pop) |=> skid_valid, "stalled beat not held in skid")

endmodule

>>> hw/rtl/dec_hex_unsigned_parser.sv
// ----------------------------------------------------------------------------
// dec_hex_unsigned_parser
// Streaming parser of one unsigned decimal or 0x-prefixed hex number.
// ----------------------------------------------------------------------------
// Usage:
//   text   : one beat per character, or at_end for the end of the text.
//   result : one beat per parsed number, sent on the terminating beat
//            (a non-digit, at_end or an overflowing digit), which is dropped and not counted.
// Throughput: one text beat per cycle while the result buffer has room,
//   also while results are produced; the accumulate step (shift-add by
//   10 or 16) is combinational logic behind the input register.
// Path: a terminating beat is held in the input register, and its result
//   is registered in the result buffer before it reaches the result channel.
// Stall: a two-entry result buffer with a registered ready keeps text
//   ready free of any path from result ready; when both entries are full,
//   text beats that end no number still pass, and a terminating beat waits
//   in the input register, stalling text, until the receiver drains one.
// Reset: rst clears the buffers and returns the parser to the start of a
//   number with zero value and count.
// ----------------------------------------------------------------------------
module dec_hex_unsigned_parser #(
  parameter int VALUE_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  dhp_text_if.sink     text,
  dhp_result_if.source result
);
  import dhp_pkg::*;

  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_data;

  dhp_core #(
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (text.valid),
    .in_ready  (text.ready),
    .in_ch     (text.ch),
    .in_at_end (text.at_end),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  dhp_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push_valid (res_valid),
    .push_ready (res_ready),
    .push_data  (res),
    .pop_valid  (result.valid),
    .pop_ready  (result.ready),
    .pop_data   (out_data)
  );

  assign result.value    = out_data.value;
  assign result.status   = out_data.status;
  assign result.consumed = out_data.consumed;
  assign result.was_hex  = out_data.was_hex;

endmodule
